[hw/rtl/tpsc_pkg.sv]
// Shared types, widths and codes of the triangle plane side classifier.
package tpsc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int VREG_W      = 48;
  localparam int TOL_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int EDGE_LIMIT  = 24;
  localparam int EDGE_SHIFT  = (COORD_WIDTH > EDGE_LIMIT) ? COORD_WIDTH - EDGE_LIMIT : 0;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int EDGE_W      = DIFF_W - EDGE_SHIFT;
  localparam int CROSS_W     = 2 * EDGE_W + 1;
  localparam int CR_W        = (CROSS_W > 32) ? CROSS_W : 32;
  localparam int FRAC_BITS   = 14;
  localparam int NORM_W      = 18;
  localparam int SQ_W        = 64;
  localparam int NUM_W       = 48;
  localparam int QUO_W       = 17;
  localparam int CNT_W       = 5;
  localparam int PROD_W      = DIFF_W + NORM_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int CMP_W       = (SUM_W > TOL_W + FRAC_BITS + 1) ? SUM_W : TOL_W + FRAC_BITS + 1;

  localparam logic [1:0] CLS_COPLANAR = 2'd0;
  localparam logic [1:0] CLS_FRONT    = 2'd1;
  localparam logic [1:0] CLS_BACK     = 2'd2;
  localparam logic [1:0] CLS_SPAN     = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_A = 3'd0,
    REG_PLANE_B = 3'd1,
    REG_PLANE_C = 3'd2,
    REG_TOL     = 3'd3,
    REG_FLIP    = 3'd4
  } cfg_reg_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t vert_a_x;
    coord_t vert_a_y;
    coord_t vert_a_z;
    coord_t vert_b_x;
    coord_t vert_b_y;
    coord_t vert_b_z;
    coord_t vert_c_x;
    coord_t vert_c_y;
    coord_t vert_c_z;
  } in_req_t;

  typedef struct packed {
    logic [1:0] side_class;
    logic [1:0] class_a;
    logic [1:0] class_b;
    logic [1:0] class_c;
    logic       degenerate_plane;
  } out_res_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] n_x;
    logic signed [NORM_W-1:0] n_y;
    logic signed [NORM_W-1:0] n_z;
    coord_t                   a_x;
    coord_t                   a_y;
    coord_t                   a_z;
    logic                     degenerate;
  } plane_t;

  // Lane k of a packed vertex register; lanes reaching past the register read as zero.
  function automatic coord_t lane_of(logic [VREG_W-1:0] r, int unsigned k);
    logic [VREG_W+3*COORD_WIDTH-1:0] w;
    w = {{(3*COORD_WIDTH){1'b0}}, r};
    return w[k*COORD_WIDTH +: COORD_WIDTH];
  endfunction

endpackage

[hw/rtl/tpsc_plane_setup.sv]
// Sequencer that derives the unit plane normal from the configured triangle.
module tpsc_plane_setup (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [tpsc_pkg::VREG_W-1:0]   va,
  input  logic [tpsc_pkg::VREG_W-1:0]   vb,
  input  logic [tpsc_pkg::VREG_W-1:0]   vc,
  output logic                          busy,
  output tpsc_pkg::plane_t              plane
);
  import tpsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE, S_MUL, S_CROSS, S_MAX, S_NORM, S_SQ, S_SUM,
    S_SQRT, S_DIVI, S_DIV, S_DONE
  } state_t;

  state_t                    state_r;
  logic signed [EDGE_W-1:0]  e1_r [3];
  logic signed [EDGE_W-1:0]  e2_r [3];
  logic signed [2*EDGE_W-1:0] p_r [6];
  logic signed [CR_W-1:0]    cr_r [3];
  logic [CR_W-1:0]           m_r;
  logic [SQ_W-1:0]           sq_r [3];
  logic [SQ_W-1:0]           rem_r, root_r, bit_r;
  logic [NUM_W-1:0]          num_r [3];
  logic [NUM_W-1:0]          den_r;
  logic [QUO_W-1:0]          q_r [3];
  logic [CNT_W-1:0]          cnt_r;
  plane_t                    plane_r;

  logic signed [EDGE_W-1:0]  e1_nxt [3];
  logic signed [EDGE_W-1:0]  e2_nxt [3];
  logic signed [2*EDGE_W-1:0] p_nxt [6];
  logic signed [CR_W-1:0]    cr_nxt [3];
  logic [CR_W-1:0]           ab [3];
  logic [CR_W-1:0]           mx;
  logic signed [31:0]        c32 [3];
  logic signed [63:0]        sqp [3];
  logic [SQ_W-1:0]           trial;
  logic                      ge [3];
  logic signed [NORM_W-1:0]  qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [DIFF_W-1:0] d1, d2;
      d1 = DIFF_W'(lane_of(vb, i)) - DIFF_W'(lane_of(va, i));
      d2 = DIFF_W'(lane_of(vc, i)) - DIFF_W'(lane_of(va, i));
      e1_nxt[i] = EDGE_W'(d1 >>> EDGE_SHIFT);
      e2_nxt[i] = EDGE_W'(d2 >>> EDGE_SHIFT);
    end
    p_nxt[0] = e1_r[1] * e2_r[2];
    p_nxt[1] = e1_r[2] * e2_r[1];
    p_nxt[2] = e1_r[2] * e2_r[0];
    p_nxt[3] = e1_r[0] * e2_r[2];
    p_nxt[4] = e1_r[0] * e2_r[1];
    p_nxt[5] = e1_r[1] * e2_r[0];
    for (int i = 0; i < 3; i++) begin
      cr_nxt[i] = CR_W'(p_r[2*i]) - CR_W'(p_r[2*i+1]);
      ab[i]     = cr_r[i][CR_W-1] ? CR_W'(-cr_r[i]) : CR_W'(cr_r[i]);
      c32[i]    = cr_r[i][31:0];
      sqp[i]    = c32[i] * c32[i];
      ge[i]     = (num_r[i] >= den_r);
      qs[i]     = NORM_W'(q_r[i]);
      if (cr_r[i][CR_W-1]) begin
        qs[i] = -qs[i];
      end
    end
    mx = ab[0];
    if (ab[1] > mx) begin
      mx = ab[1];
    end
    if (ab[2] > mx) begin
      mx = ab[2];
    end
    trial = root_r + bit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_EDGE;
      plane_r.degenerate <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (go) begin
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          e1_r        <= e1_nxt;
          e2_r        <= e2_nxt;
          plane_r.a_x <= lane_of(va, 0);
          plane_r.a_y <= lane_of(va, 1);
          plane_r.a_z <= lane_of(va, 2);
          state_r     <= S_MUL;
        end
        S_MUL: begin
          p_r     <= p_nxt;
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          cr_r    <= cr_nxt;
          state_r <= S_MAX;
        end
        S_MAX: begin
          if (mx == '0) begin
            plane_r.degenerate <= 1'b1;
            state_r            <= S_IDLE;
          end else begin
            m_r     <= mx;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // Bring the largest component into [2^29, 2^30) one bit a cycle.
          if (m_r >= (CR_W'(1) << 30)) begin
            m_r <= m_r >> 1;
            for (int i = 0; i < 3; i++) begin
              cr_r[i] <= cr_r[i] >>> 1;
            end
          end else if (m_r < (CR_W'(1) << 29)) begin
            m_r <= m_r << 1;
            for (int i = 0; i < 3; i++) begin
              cr_r[i] <= cr_r[i] <<< 1;
            end
          end else begin
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          for (int i = 0; i < 3; i++) begin
            sq_r[i] <= unsigned'(sqp[i]);
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          rem_r   <= sq_r[0] + sq_r[1] + sq_r[2];
          root_r  <= '0;
          bit_r   <= SQ_W'(1) << 62;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (rem_r >= trial) begin
            rem_r  <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= S_DIVI;
          end
        end
        S_DIVI: begin
          for (int i = 0; i < 3; i++) begin
            num_r[i] <= (NUM_W'(ab[i]) << FRAC_BITS) + NUM_W'(root_r >> 1);
            q_r[i]   <= '0;
          end
          den_r   <= NUM_W'(root_r) << (QUO_W - 1);
          cnt_r   <= CNT_W'(QUO_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (ge[i]) begin
              num_r[i] <= num_r[i] - den_r;
            end
            q_r[i] <= {q_r[i][QUO_W-2:0], ge[i]};
          end
          den_r <= den_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          plane_r.n_x        <= qs[0];
          plane_r.n_y        <= qs[1];
          plane_r.n_z        <= qs[2];
          plane_r.degenerate <= 1'b0;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign plane = plane_r;

endmodule

[hw/rtl/tpsc_dist_lane.sv]
// One vertex lane: signed plane distance and its side code over three stages.
module tpsc_dist_lane (
  input  logic                        clk,
  input  tpsc_pkg::coord_t            p_x,
  input  tpsc_pkg::coord_t            p_y,
  input  tpsc_pkg::coord_t            p_z,
  input  tpsc_pkg::plane_t            plane,
  input  logic [tpsc_pkg::TOL_W-1:0]  tol,
  input  logic                        flipped,
  output logic [1:0]                  cls
);
  import tpsc_pkg::*;

  logic signed [DIFF_W-1:0] diff_r [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic [1:0]               cls_r;
  logic signed [SUM_W-1:0]  dist_sum;
  logic [CMP_W-1:0]         mag;
  logic [CMP_W-1:0]         tol_s;
  logic                     neg;
  logic [1:0]               cls_nxt;

  always_comb begin
    dist_sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
    neg      = dist_sum[SUM_W-1];
    mag      = neg ? CMP_W'(unsigned'(-dist_sum)) : CMP_W'(unsigned'(dist_sum));
    tol_s    = CMP_W'({tol, {FRAC_BITS{1'b0}}});
    if (mag < tol_s) begin
      cls_nxt = CLS_COPLANAR;
    end else if (flipped ? neg : (!neg && dist_sum != '0)) begin
      cls_nxt = CLS_FRONT;
    end else begin
      cls_nxt = CLS_BACK;
    end
  end

  always_ff @(posedge clk) begin
    diff_r[0] <= DIFF_W'(p_x) - DIFF_W'(plane.a_x);
    diff_r[1] <= DIFF_W'(p_y) - DIFF_W'(plane.a_y);
    diff_r[2] <= DIFF_W'(p_z) - DIFF_W'(plane.a_z);
    prod_r[0] <= PROD_W'(plane.n_x) * PROD_W'(diff_r[0]);
    prod_r[1] <= PROD_W'(plane.n_y) * PROD_W'(diff_r[1]);
    prod_r[2] <= PROD_W'(plane.n_z) * PROD_W'(diff_r[2]);
    cls_r     <= cls_nxt;
  end

  assign cls = cls_r;

endmodule

[hw/rtl/triangle_plane_side_classifier_unit.sv]
// Top level: configuration registers, plane setup, three vertex lanes and the merge stage.
// An accepted request passes the lane and result registers to a one-cycle out_valid strobe.
// Throughput is one request per cycle while busy is low; the receiver cannot stall.
// Writing a plane vertex register reruns the normal setup, set mostly by the bit-serial
// square root and divider and cut short for a degenerate triangle; busy is high.
// Synchronous active-low reset clears the registers to their defaults and starts setup.
module triangle_plane_side_classifier_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  tpsc_pkg::in_req_t                 in_req,
  output logic                              out_valid,
  output tpsc_pkg::out_res_t                out_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tpsc_pkg::*;

  logic [VREG_W-1:0] va_r, vb_r, vc_r;
  logic [TOL_W-1:0]  tol_r;
  logic              flip_r;
  logic              setup_go;
  logic              setup_busy;
  logic              cfg_wr;
  plane_t            plane;
  logic [2:0]        vld_r;
  logic [1:0]        cls [3];
  logic [1:0]        ca, cb, cc;
  out_res_t          res_r;
  logic              out_valid_r;

  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_ready = !setup_busy;
  assign busy      = setup_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= '0;
      vb_r   <= '0;
      vc_r   <= '0;
      tol_r  <= TOL_W'(1);
      flip_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_PLANE_A: va_r   <= cfg_data[VREG_W-1:0];
        REG_PLANE_B: vb_r   <= cfg_data[VREG_W-1:0];
        REG_PLANE_C: vc_r   <= cfg_data[VREG_W-1:0];
        REG_TOL:     tol_r  <= cfg_data[TOL_W-1:0];
        REG_FLIP:    flip_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    setup_go = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_index) inside
        REG_PLANE_A, REG_PLANE_B, REG_PLANE_C: setup_go = 1'b1;
        default: setup_go = 1'b0;
      endcase
    end
  end

  tpsc_plane_setup u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (setup_go),
    .va    (va_r),
    .vb    (vb_r),
    .vc    (vc_r),
    .busy  (setup_busy),
    .plane (plane)
  );

  tpsc_dist_lane u_lane_a (
    .clk (clk), .p_x (in_req.vert_a_x), .p_y (in_req.vert_a_y), .p_z (in_req.vert_a_z),
    .plane (plane), .tol (tol_r), .flipped (flip_r), .cls (cls[0])
  );

  tpsc_dist_lane u_lane_b (
    .clk (clk), .p_x (in_req.vert_b_x), .p_y (in_req.vert_b_y), .p_z (in_req.vert_b_z),
    .plane (plane), .tol (tol_r), .flipped (flip_r), .cls (cls[1])
  );

  tpsc_dist_lane u_lane_c (
    .clk (clk), .p_x (in_req.vert_c_x), .p_y (in_req.vert_c_y), .p_z (in_req.vert_c_z),
    .plane (plane), .tol (tol_r), .flipped (flip_r), .cls (cls[2])
  );

  // A degenerate plane compares like NaN, so every vertex lands behind it.
  assign ca = plane.degenerate ? CLS_BACK : cls[0];
  assign cb = plane.degenerate ? CLS_BACK : cls[1];
  assign cc = plane.degenerate ? CLS_BACK : cls[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[1:0], start && !busy};
      out_valid_r <= vld_r[2];
    end
    res_r.class_a          <= ca;
    res_r.class_b          <= cb;
    res_r.class_c          <= cc;
    res_r.side_class       <= ca | cb | cc;
    res_r.degenerate_plane <= plane.degenerate;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##3 out_valid)
    else $error("accepted request did not produce a result after four cycles");

  a_degen_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.degenerate_plane |-> out_res.side_class == CLS_BACK)
    else $error("degenerate plane result not classed as back");

  a_setup_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready &&
    (cfg_index == REG_PLANE_A || cfg_index == REG_PLANE_B || cfg_index == REG_PLANE_C)
    |=> busy)
    else $error("plane vertex write did not start normal setup");

  a_coplanar_all: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.side_class == CLS_COPLANAR |->
    out_res.class_a == CLS_COPLANAR && out_res.class_b == CLS_COPLANAR &&
    out_res.class_c == CLS_COPLANAR)
    else $error("coplanar side with a non-coplanar vertex");

endmodule
